// ===== design/sbmp_pkg.sv =====
// ============================================================================
// sbmp_pkg: shared types and constants for the bone matrix palette
// Element width, store depth, a rounding helper and the control struct.
// ============================================================================
package sbmp_pkg;

    localparam int MaxNodes  = 256;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int StoreAw   = $clog2(MaxNodes * 16);
    localparam int NumCells  = 4;

    // Register indexes of the inverse root rows.
    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;
    localparam logic [1:0] REG_ROW3 = 2'd3;

    typedef logic signed [15:0] elem_t;
    typedef logic [63:0]        row_t;

    // Control word that travels along the chain of multiply cells.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [1:0] row;
        logic [1:0] col;
    } cell_ctl_t;

    // Round to nearest, shift by the fraction width and saturate.
    function automatic elem_t round_sat(input logic signed [33:0] s);
        logic signed [33:0] t;
        logic signed [25:0] q;
        begin
            t = s + 34'sd128;
            q = t[33:8];
            if (q > 26'sd32767) begin
                round_sat = 16'sh7fff;
            end else if (q < -26'sd32768) begin
                round_sat = 16'sh8000;
            end else begin
                round_sat = q[15:0];
            end
        end
    endfunction

endpackage

// ===== design/skeletal_bone_matrix_palette.sv =====
// ============================================================================
// skeletal_bone_matrix_palette: skinning matrix palette for one skeleton
// Top level with the configuration registers, input handshake and output
// register around the sequencer and its chain of multiply cells.
// ============================================================================
// Usage: skeleton nodes arrive as words on the s_ channel, parents before
// children. Each node's global matrix is formed and stored; a non-root node
// with a bone returns one word on the m_ channel carrying
// inv_root * global * offset.
// A node runs a parent fetch, its matrix products on the chain of four multiply
// cells (one dot product enters per cycle) and a write-back into the global
// store, which has one read and one write port. A root skips the products and
// a boneless node runs only the first one.
// After reset a clearing pass zeroes all 4096 store entries while s_ready
// stays low; register writes are taken during it.
// One node is in flight at a time. A finished result sits in the output
// register; the next node is accepted while it waits, but its result cannot
// leave the core until m_ready has taken the previous word.
// ============================================================================
module skeletal_bone_matrix_palette (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [8:0]  s_parent_index,
    input  logic [8:0]  s_bone_index,
    input  logic [63:0] s_local_row0,
    input  logic [63:0] s_local_row1,
    input  logic [63:0] s_local_row2,
    input  logic [63:0] s_local_row3,
    input  logic [63:0] s_offset_row0,
    input  logic [63:0] s_offset_row1,
    input  logic [63:0] s_offset_row2,
    input  logic [63:0] s_offset_row3,
    input  logic        s_last_node,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_bone,
    output logic [63:0] m_final_row0,
    output logic [63:0] m_final_row1,
    output logic [63:0] m_final_row2,
    output logic [63:0] m_final_row3,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sbmp_pkg::*;

    logic [63:0] inv_reg [4];
    logic [63:0] local_rows [4];
    logic [63:0] offset_rows [4];
    logic [63:0] res_rows [4];
    logic        busy, res_valid, start;
    logic [7:0]  res_bone;
    logic        m_valid_reg;
    logic [7:0]  bone_reg;
    logic [63:0] row_reg [4];
    logic [1:0]  reg_idx;
    logic        out_busy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    // Configuration writes; addresses past the last register are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg[0] <= 64'h0000_0000_0000_0100;
            inv_reg[1] <= 64'h0000_0000_0100_0000;
            inv_reg[2] <= 64'h0000_0100_0000_0000;
            inv_reg[3] <= 64'h0100_0000_0000_0000;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (reg_idx)
                REG_ROW0: inv_reg[0] <= pwdata;
                REG_ROW1: inv_reg[1] <= pwdata;
                REG_ROW2: inv_reg[2] <= pwdata;
                REG_ROW3: inv_reg[3] <= pwdata;
            endcase
        end
    end

    assign prdata = (paddr[2:0] == 3'd0) ? inv_reg[reg_idx] : 64'd0;

    // Take a new word only when the core is idle.
    assign s_ready = !busy && !res_valid;
    assign start   = s_valid && s_ready;

    // The output register is still held by a word that is not taken now.
    assign out_busy = m_valid_reg && !m_ready;

    assign local_rows[0]  = s_local_row0;
    assign local_rows[1]  = s_local_row1;
    assign local_rows[2]  = s_local_row2;
    assign local_rows[3]  = s_local_row3;
    assign offset_rows[0] = s_offset_row0;
    assign offset_rows[1] = s_offset_row1;
    assign offset_rows[2] = s_offset_row2;
    assign offset_rows[3] = s_offset_row3;

    sbmp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .parent_index(s_parent_index),
        .bone_index  (s_bone_index),
        .local_rows  (local_rows),
        .offset_rows (offset_rows),
        .last_node   (s_last_node),
        .inv_rows    (inv_reg),
        .out_busy    (out_busy),
        .busy        (busy),
        .res_valid   (res_valid),
        .res_bone    (res_bone),
        .res_rows    (res_rows)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            bone_reg <= res_bone;
            row_reg  <= res_rows;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_bone   = bone_reg;
    assign m_final_row0 = row_reg[0];
    assign m_final_row1 = row_reg[1];
    assign m_final_row2 = row_reg[2];
    assign m_final_row3 = row_reg[3];
endmodule

// ===== design/sbmp_cell.sv =====
// ============================================================================
// sbmp_cell: one multiply-accumulate cell of the dot product chain
// Multiplies its pair, adds the partial sum from its left neighbor, and
// passes the registered sum and control word to its right neighbor.
// ============================================================================
module sbmp_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sbmp_pkg::cell_ctl_t        ctl_in,
    input  logic signed [33:0]         sum_in,
    input  logic signed [15:0]         a_in,
    input  logic signed [15:0]         b_in,
    output sbmp_pkg::cell_ctl_t        ctl_out,
    output logic signed [33:0]         sum_out
);
    import sbmp_pkg::*;

    cell_ctl_t          ctl_reg;
    logic signed [33:0] sum_reg;
    logic signed [31:0] prod;

    // One signed 16x16 product per cycle.
    assign prod = a_in * b_in;

    // Control word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    // Partial sum register.
    always_ff @(posedge aclk) begin
        sum_reg <= sum_in + 34'(prod);
    end

    assign ctl_out = ctl_reg;
    assign sum_out = sum_reg;
endmodule

// ===== design/sbmp_core.sv =====
// ============================================================================
// sbmp_core: sequencer, matrix stores and cell chain
// Runs up to three 4x4 products of one node through a chain of four cells,
// one dot product entering the chain per cycle, and keeps global matrices.
// ============================================================================
module sbmp_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [8:0]  parent_index,
    input  logic [8:0]  bone_index,
    input  logic [63:0] local_rows [4],
    input  logic [63:0] offset_rows [4],
    input  logic        last_node,
    input  logic [63:0] inv_rows [4],
    input  logic        out_busy,
    output logic        busy,
    output logic        res_valid,
    output logic [7:0]  res_bone,
    output logic [63:0] res_rows [4]
);
    import sbmp_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Global matrix store: one element per address, synchronous read.
    elem_t               store_mem [MaxNodes * 16];
    logic [StoreAw-1:0]  rd_addr;
    elem_t               rd_data_reg;
    logic                st_we;
    logic [StoreAw-1:0]  st_waddr;
    elem_t               st_wdata;

    logic [NodeW-1:0]    node_reg;
    logic [StoreAw:0]    clr_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          pass_reg;
    logic                par_ok_reg, is_root_reg, has_bone_reg, last_reg;
    logic [7:0]          bone_reg;
    logic [NodeW-1:0]    par_reg;

    // b_mat holds the local matrix, then the final transform; a_mat the offset;
    // g_mat the parent, then inv_root * global; t_mat the global matrix.
    elem_t a_mat [16];
    elem_t b_mat [16];
    elem_t g_mat [16];
    elem_t t_mat [16];
    elem_t inv_m [16];

    // Feed counter: cnt 0..15 issues dot products, later cycles drain.
    logic [1:0] fr, fc;
    assign fr = cnt_reg[3:2];
    assign fc = cnt_reg[1:0];

    cell_ctl_t          ctl [NumCells+1];
    logic signed [33:0] sum [NumCells+1];

    logic signed [8:0] pidx;
    assign pidx = parent_index;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            inv_m[i] = inv_rows[i/4][16*(i%4) +: 16];
        end
    end

    // The four cells each take one term k of the dot product.
    assign ctl[0].valid = (state_reg == ST_MUL) && !cnt_reg[4];
    assign ctl[0].first = 1'b0;
    assign ctl[0].last  = (cnt_reg[3:0] == 4'd15);
    assign ctl[0].row   = fr;
    assign ctl[0].col   = fc;
    assign sum[0]       = '0;

    // Operand of term k is delayed to match the cell it enters.
    logic [1:0] rk [NumCells];
    logic [1:0] ck [NumCells];
    generate
        for (genvar k = 0; k < NumCells; k++) begin : g_chain
            elem_t av, bv;
            assign rk[k] = (k == 0) ? fr : ctl[k].row;
            assign ck[k] = (k == 0) ? fc : ctl[k].col;
            always_comb begin
                unique case (pass_reg)
                    2'd0: begin
                        av = par_ok_reg ? g_mat[{rk[k], 2'(k)}] : 16'sd0;
                        bv = b_mat[{2'(k), ck[k]}];
                    end
                    2'd1: begin
                        av = inv_m[{rk[k], 2'(k)}];
                        bv = t_mat[{2'(k), ck[k]}];
                    end
                    default: begin
                        av = g_mat[{rk[k], 2'(k)}];
                        bv = a_mat[{2'(k), ck[k]}];
                    end
                endcase
            end
            sbmp_cell u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .ctl_in (ctl[k]),
                .sum_in (sum[k]),
                .a_in   (av),
                .b_in   (bv),
                .ctl_out(ctl[k+1]),
                .sum_out(sum[k+1])
            );
        end
    endgenerate

    // Store port: clearing pass, parent fetch and global write-back.
    assign rd_addr = {par_reg, cnt_reg[3:0]};
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = clr_reg[StoreAw-1:0];
        st_wdata = 16'sd0;
        if (state_reg == ST_CLEAR) begin
            st_we = 1'b1;
        end else if (state_reg == ST_WRITE) begin
            st_we    = 1'b1;
            st_waddr = {node_reg, cnt_reg[3:0]};
            st_wdata = t_mat[cnt_reg[3:0]];
        end
    end

    // Next state. A root skips the products; a result waits for the output.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (StoreAw+1)'(MaxNodes*16 - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_FETCH;
            ST_FETCH: if (cnt_reg == 5'd16) state_next = is_root_reg ? ST_WRITE : ST_MUL;
            ST_MUL: begin
                if (ctl[NumCells].valid && ctl[NumCells].last) begin
                    if (pass_reg == 2'd0 && !has_bone_reg) state_next = ST_WRITE;
                    else if (pass_reg == 2'd2) state_next = ST_DONE;
                end
            end
            ST_WRITE: if (cnt_reg == 5'd15) state_next = ST_IDLE;
            ST_DONE:  if (!out_busy) state_next = ST_WRITE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            node_reg  <= '0;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            res_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_valid <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    cnt_reg  <= '0;
                    pass_reg <= '0;
                end
                ST_FETCH: cnt_reg <= (cnt_reg == 5'd16) ? 5'd0 : cnt_reg + 1'b1;
                ST_MUL: begin
                    if (!cnt_reg[4]) cnt_reg <= cnt_reg + 1'b1;
                    if (ctl[NumCells].valid && ctl[NumCells].last) begin
                        cnt_reg  <= '0;
                        pass_reg <= pass_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!out_busy) res_valid <= 1'b1;
                    cnt_reg <= '0;
                end
                ST_WRITE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd15) begin
                        node_reg <= (last_reg || node_reg == NodeW'(MaxNodes - 1))
                                    ? '0 : node_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Node decode, operand capture, parent fetch and results.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            is_root_reg  <= (pidx == -9'sd1);
            par_ok_reg   <= !pidx[8] && (pidx[NodeW-1:0] < node_reg) &&
                            (pidx[8:NodeW] == '0);
            par_reg      <= pidx[NodeW-1:0];
            has_bone_reg <= (pidx != -9'sd1) && !bone_index[8];
            bone_reg     <= bone_index[7:0];
            last_reg     <= last_node;
            for (int i = 0; i < 16; i++) begin
                b_mat[i] <= local_rows[i/4][16*(i%4) +: 16];
                a_mat[i] <= offset_rows[i/4][16*(i%4) +: 16];
            end
        end
        if (state_reg == ST_FETCH && cnt_reg != 5'd0) begin
            g_mat[cnt_reg[3:0] - 4'd1] <= rd_data_reg;
        end
        if (state_reg == ST_FETCH && cnt_reg == 5'd16 && is_root_reg) begin
            // A root skips the products: its global matrix is the local one.
            t_mat <= b_mat;
        end
        if (state_reg == ST_MUL && ctl[NumCells].valid) begin
            unique case (pass_reg)
                2'd0: t_mat[{ctl[NumCells].row, ctl[NumCells].col}] <=
                          round_sat(sum[NumCells]);
                2'd1: g_mat[{ctl[NumCells].row, ctl[NumCells].col}] <=
                          round_sat(sum[NumCells]);
                default: b_mat[{ctl[NumCells].row, ctl[NumCells].col}] <=
                          round_sat(sum[NumCells]);
            endcase
        end
        if (state_reg == ST_DONE) begin
            res_bone <= bone_reg;
            for (int r = 0; r < 4; r++) begin
                res_rows[r] <= {b_mat[4*r+3], b_mat[4*r+2], b_mat[4*r+1], b_mat[4*r]};
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

// ===== design/sbmp_checker.sv =====
// ============================================================================
// sbmp_checker: port-level checks for the bone matrix palette
// Watches the handshakes and APB port of the top level.
// ============================================================================
module sbmp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic pready
);
    // The block never stalls the configuration port.
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    // A result word holds until it is taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped");

    // No node is taken in the cycle right after one was taken.
    a_one_node: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted too early");

    // Nothing is accepted in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("activity right after reset");
endmodule

bind skeletal_bone_matrix_palette sbmp_checker u_sbmp_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .pready (pready)
);
